/* src/ffc_pkg.sv */
// shared types, constants and tables for the fiducial follow controller
package ffc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ,
        S_SQRT,
        S_NUM,
        S_DCHK,
        S_DIVD,
        S_MULX,
        S_DIVX,
        S_XFIN,
        S_CINIT_Y,
        S_CORD_Y,
        S_CFIN_Y,
        S_CINIT_L,
        S_CORD_L,
        S_CFIN_L,
        S_MULL,
        S_MULA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] edge_len;
        logic [15:0] focal_x;
        logic [13:0] principal_x;
        logic [15:0] range_set;
        logic [15:0] range_gain;
        logic [15:0] head_gain;
        logic [13:0] lin_limit;
        logic [14:0] rot_limit;
    } t_cfg;

    typedef struct packed {
        t_state     op;
        logic [4:0] step;
        logic       load_in;
        logic       load_out;
        logic       stop;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    localparam logic [3:0] CFG_EDGE_LEN    = 4'd0;
    localparam logic [3:0] CFG_FOCAL_X     = 4'd1;
    localparam logic [3:0] CFG_PRINCIPAL_X = 4'd2;
    localparam logic [3:0] CFG_RANGE_SET   = 4'd3;
    localparam logic [3:0] CFG_RANGE_GAIN  = 4'd4;
    localparam logic [3:0] CFG_HEAD_GAIN   = 4'd5;
    localparam logic [3:0] CFG_LIN_LIMIT   = 4'd6;
    localparam logic [3:0] CFG_ROT_LIMIT   = 4'd7;

    localparam logic [15:0] RST_EDGE_LEN    = 16'd3277;
    localparam logic [15:0] RST_FOCAL_X     = 16'd4944;
    localparam logic [13:0] RST_PRINCIPAL_X = 14'd5120;
    localparam logic [15:0] RST_RANGE_SET   = 16'd2458;
    localparam logic [15:0] RST_RANGE_GAIN  = 16'd3277;
    localparam logic [15:0] RST_HEAD_GAIN   = 16'd8192;
    localparam logic [13:0] RST_LIN_LIMIT   = 14'd1229;
    localparam logic [14:0] RST_ROT_LIMIT   = 15'd4096;

    localparam logic [2:0]  MISS_LIMIT = 3'd3;
    localparam logic [2:0]  MISS_MAX   = 3'd7;

    localparam int SQRT_STEPS = 19;
    localparam int DIVD_STEPS = 16;
    localparam int DIVX_STEPS = 30;
    localparam int CORD_STEPS = 16;

    localparam logic signed [18:0] ROT_Q16     = 19'sd102944;
    localparam logic signed [14:0] PI_Q12      = 15'sd12868;
    localparam logic [16:0]        DEADBAND    = 17'd410;
    localparam logic [13:0]        LIN_CAP     = 14'd8192;
    localparam logic [14:0]        ANG_CAP     = 15'd16384;

    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            4'd15:   v = 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/ffc_ctrl.sv */
// sequencer for the range, offset, angle and speed computation
module ffc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_tag_found,
    input  ffc_pkg::t_status  i_status,
    output ffc_pkg::t_cmd     o_cmd,
    output logic              o_in_ready
);

    ffc_pkg::t_state r_state, n_state;
    logic [4:0]      r_step, n_step;
    logic [2:0]      r_miss, n_miss;
    logic            r_stop, n_stop;
    logic            accept;
    logic [2:0]      miss_inc;

    assign accept   = (r_state == ffc_pkg::S_IDLE) && i_in_valid;
    assign miss_inc = (r_miss == ffc_pkg::MISS_MAX) ? r_miss : r_miss + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffc_pkg::S_IDLE;
            r_step  <= '0;
            r_miss  <= '0;
            r_stop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_miss  <= n_miss;
            r_stop  <= n_stop;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step - 5'd1;
        n_miss  = r_miss;
        n_stop  = r_stop;
        case (r_state)
            ffc_pkg::S_IDLE: begin
                if (accept) begin
                    n_stop = ~i_tag_found;
                    if (i_tag_found) begin
                        n_miss  = '0;
                        n_state = ffc_pkg::S_SQ;
                    end else begin
                        n_miss = miss_inc;
                        if (miss_inc > ffc_pkg::MISS_LIMIT) n_state = ffc_pkg::S_DONE;
                    end
                end
            end
            ffc_pkg::S_SQ: begin
                n_state = ffc_pkg::S_SQRT;
                n_step  = 5'(ffc_pkg::SQRT_STEPS - 1);
            end
            ffc_pkg::S_SQRT: begin
                if (r_step == '0) n_state = ffc_pkg::S_NUM;
            end
            ffc_pkg::S_NUM: n_state = ffc_pkg::S_DCHK;
            ffc_pkg::S_DCHK: begin
                n_state = ffc_pkg::S_DIVD;
                n_step  = 5'(ffc_pkg::DIVD_STEPS - 1);
            end
            ffc_pkg::S_DIVD: begin
                if (r_step == '0) n_state = ffc_pkg::S_MULX;
            end
            ffc_pkg::S_MULX: begin
                n_state = ffc_pkg::S_DIVX;
                n_step  = 5'(ffc_pkg::DIVX_STEPS - 1);
            end
            ffc_pkg::S_DIVX: begin
                if (r_step == '0) n_state = ffc_pkg::S_XFIN;
            end
            ffc_pkg::S_XFIN: n_state = ffc_pkg::S_CINIT_Y;
            ffc_pkg::S_CINIT_Y: begin
                n_state = ffc_pkg::S_CORD_Y;
                n_step  = 5'(ffc_pkg::CORD_STEPS - 1);
            end
            ffc_pkg::S_CORD_Y: begin
                if (r_step == '0) n_state = ffc_pkg::S_CFIN_Y;
            end
            ffc_pkg::S_CFIN_Y: n_state = ffc_pkg::S_CINIT_L;
            ffc_pkg::S_CINIT_L: begin
                n_state = ffc_pkg::S_CORD_L;
                n_step  = 5'(ffc_pkg::CORD_STEPS - 1);
            end
            ffc_pkg::S_CORD_L: begin
                if (r_step == '0) n_state = ffc_pkg::S_CFIN_L;
            end
            ffc_pkg::S_CFIN_L: n_state = ffc_pkg::S_MULL;
            ffc_pkg::S_MULL:   n_state = ffc_pkg::S_MULA;
            ffc_pkg::S_MULA:   n_state = ffc_pkg::S_DONE;
            ffc_pkg::S_DONE: begin
                if (i_status.out_free) n_state = ffc_pkg::S_IDLE;
            end
            default: n_state = ffc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op       = r_state;
        o_cmd.step     = r_step;
        o_cmd.stop     = r_stop;
        o_cmd.load_in  = accept;
        o_cmd.load_out = (r_state == ffc_pkg::S_DONE) && i_status.out_free;
        o_in_ready     = (r_state == ffc_pkg::S_IDLE);
    end

endmodule

/* src/ffc_dp.sv */
// datapath: square root, dividers, shared cordic, gains and output register
module ffc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffc_pkg::t_cmd       i_cmd,
    input  ffc_pkg::t_cfg       i_cfg,
    output ffc_pkg::t_status    o_status,
    input  logic [13:0]         i_corner0_x,
    input  logic [13:0]         i_corner0_y,
    input  logic [13:0]         i_corner1_x,
    input  logic [13:0]         i_corner1_y,
    input  logic [13:0]         i_corner2_x,
    input  logic [13:0]         i_corner2_y,
    input  logic [13:0]         i_centre_x,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_forward_distance,
    output logic signed [15:0]  o_lateral_position,
    output logic signed [14:0]  o_yaw_angle,
    output logic signed [14:0]  o_linear_speed,
    output logic signed [15:0]  o_angular_speed,
    output logic                o_is_stop
);

    logic signed [14:0] r_dx, r_dy, r_yx, r_yy;
    logic [13:0]        r_cx;
    logic [37:0]        r_rad;
    logic [38:0]        r_root;
    logic [31:0]        r_num;
    logic               r_dsat;
    logic [18:0]        r_rem;
    logic [15:0]        r_qd;
    logic               r_xneg;
    logic [29:0]        r_xq;
    logic [15:0]        r_xrem;
    logic signed [15:0] r_xs;
    logic signed [15:0] r_lat_pos;
    logic signed [26:0] r_crx, r_cry;
    logic signed [18:0] r_crz;
    logic               r_czero;
    logic signed [14:0] r_yaw, r_lat;
    logic signed [33:0] r_linp, r_angp;
    logic               r_dead;
    logic               r_ovalid;

    // sum of squares
    logic signed [29:0] sqx, sqy;
    logic [30:0]        sumsq;
    assign sqx   = r_dx * r_dx;
    assign sqy   = r_dy * r_dy;
    assign sumsq = {1'b0, sqx} + {1'b0, sqy};

    // square root step
    logic [38:0] sbit, strial;
    logic        sge;
    assign sbit   = 39'd1 << {i_cmd.step, 1'b0};
    assign strial = r_root + sbit;
    assign sge    = {1'b0, r_rad} >= strial;

    logic [18:0] len;
    assign len = r_root[18:0];

    // range division step
    logic [19:0] drem2;
    logic        dge;
    assign drem2 = {r_rem, r_qd[15]};
    assign dge   = drem2 >= {1'b0, len};

    logic [15:0] rng;
    assign rng = r_dsat ? 16'hFFFF : r_qd;

    // camera x product and division step
    logic signed [14:0] off;
    logic signed [31:0] xprod;
    logic [16:0]        xrem2;
    logic               xge;
    assign off   = $signed({1'b0, r_cx}) - $signed({1'b0, i_cfg.principal_x});
    assign xprod = off * $signed({1'b0, rng});
    assign xrem2 = {r_xrem, r_xq[29]};
    assign xge   = xrem2 >= {1'b0, i_cfg.focal_x};

    logic [29:0]        xmag;
    logic signed [30:0] xval, xneg_val;
    assign xmag     = (i_cfg.focal_x == '0) ? '0 : r_xq;
    assign xval     = r_xneg ? -$signed({1'b0, xmag}) : $signed({1'b0, xmag});
    assign xneg_val = -xval;

    // cordic
    logic               lat_sel;
    logic signed [16:0] ax, ay;
    logic signed [26:0] sx, sy;
    logic [3:0]         ci;
    logic signed [26:0] xsh, ysh;
    logic signed [18:0] ctab;
    logic signed [18:0] zr;
    logic signed [14:0] zang;

    assign lat_sel = (i_cmd.op == ffc_pkg::S_CINIT_L);
    assign ax = lat_sel ? $signed({1'b0, rng}) : 17'(r_yx);
    assign ay = lat_sel ? 17'(r_xs) : 17'(r_yy);
    assign sx = 27'(ax) <<< 8;
    assign sy = 27'(ay) <<< 8;
    assign ci   = 4'(5'(ffc_pkg::CORD_STEPS - 1) - i_cmd.step);
    assign xsh  = r_crx >>> ci;
    assign ysh  = r_cry >>> ci;
    assign ctab = $signed({3'b0, ffc_pkg::atan_q16(ci)});
    assign zr   = (r_crz + 19'sd8) >>> 4;
    assign zang = r_czero ? 15'sd0 :
                  (zr > 19'(ffc_pkg::PI_Q12)) ? ffc_pkg::PI_Q12 :
                  (zr < -19'(ffc_pkg::PI_Q12)) ? -ffc_pkg::PI_Q12 : 15'(zr);

    // speeds
    logic signed [16:0] err;
    logic [16:0]        aerr;
    logic signed [16:0] asum;
    assign err  = $signed({1'b0, rng}) - $signed({1'b0, i_cfg.range_set});
    assign aerr = err[16] ? 17'(-err) : 17'(err);
    assign asum = (17'(r_lat) <<< 1) + 17'(r_yaw);

    logic signed [21:0] lsh;
    logic signed [20:0] ash;
    logic [13:0]        llim;
    logic [14:0]        alim;
    logic signed [14:0] lin;
    logic signed [15:0] ang;
    assign lsh  = 22'(r_linp >>> 12);
    assign ash  = 21'(r_angp >>> 13);
    assign llim = (i_cfg.lin_limit > ffc_pkg::LIN_CAP) ? ffc_pkg::LIN_CAP : i_cfg.lin_limit;
    assign alim = (i_cfg.rot_limit > ffc_pkg::ANG_CAP) ? ffc_pkg::ANG_CAP
                                                        : i_cfg.rot_limit;
    assign lin = r_dead ? 15'sd0 :
                 (lsh > $signed({8'b0, llim})) ? $signed({1'b0, llim}) :
                 (lsh < -$signed({8'b0, llim})) ? -$signed({1'b0, llim}) : 15'(lsh);
    assign ang = (ash > $signed({6'b0, alim})) ? $signed({1'b0, alim}) :
                 (ash < -$signed({6'b0, alim})) ? -$signed({1'b0, alim}) : 16'(ash);

    assign o_status.out_free = ~r_ovalid | i_out_ready;
    assign o_out_valid       = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dx <= $signed({1'b0, i_corner0_x}) - $signed({1'b0, i_corner1_x});
            r_dy <= $signed({1'b0, i_corner0_y}) - $signed({1'b0, i_corner1_y});
            r_yx <= $signed({1'b0, i_corner0_x}) - $signed({1'b0, i_corner2_x});
            r_yy <= $signed({1'b0, i_corner0_y}) - $signed({1'b0, i_corner2_y});
            r_cx <= i_centre_x;
        end
        case (i_cmd.op)
            ffc_pkg::S_SQ: begin
                r_rad  <= {sumsq[29:0], 8'b0};
                r_root <= '0;
            end
            ffc_pkg::S_SQRT: begin
                if (sge) begin
                    r_rad  <= r_rad - strial[37:0];
                    r_root <= (r_root >> 1) + sbit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            ffc_pkg::S_NUM: r_num <= i_cfg.edge_len * i_cfg.focal_x;
            ffc_pkg::S_DCHK: begin
                r_dsat <= (len == '0) || ({3'b0, r_num[31:16]} >= len);
                r_rem  <= {3'b0, r_num[31:16]};
                r_qd   <= r_num[15:0];
            end
            ffc_pkg::S_DIVD: begin
                r_rem <= dge ? 19'(drem2 - {1'b0, len}) : drem2[18:0];
                r_qd  <= {r_qd[14:0], dge};
            end
            ffc_pkg::S_MULX: begin
                r_xneg <= xprod[31];
                r_xq   <= xprod[31] ? 30'(-xprod) : xprod[29:0];
                r_xrem <= '0;
            end
            ffc_pkg::S_DIVX: begin
                r_xrem <= xge ? 16'(xrem2 - {1'b0, i_cfg.focal_x}) : xrem2[15:0];
                r_xq   <= {r_xq[28:0], xge};
            end
            ffc_pkg::S_XFIN: begin
                r_xs <= (xval > 31'sd32767) ? 16'sd32767 :
                        (xval < -31'sd32768) ? -16'sd32768 : 16'(xval);
                r_lat_pos <= (xneg_val > 31'sd32767) ? 16'sd32767 :
                             (xneg_val < -31'sd32768) ? -16'sd32768 : 16'(xneg_val);
            end
            ffc_pkg::S_CINIT_Y, ffc_pkg::S_CINIT_L: begin
                r_czero <= (ax == '0) && (ay == '0);
                if (sx < 0) begin
                    if (sy >= 0) begin
                        r_crx <= sy;
                        r_cry <= -sx;
                        r_crz <= ffc_pkg::ROT_Q16;
                    end else begin
                        r_crx <= -sy;
                        r_cry <= sx;
                        r_crz <= -ffc_pkg::ROT_Q16;
                    end
                end else begin
                    r_crx <= sx;
                    r_cry <= sy;
                    r_crz <= '0;
                end
            end
            ffc_pkg::S_CORD_Y, ffc_pkg::S_CORD_L: begin
                if (r_cry >= 0) begin
                    r_crx <= r_crx + ysh;
                    r_cry <= r_cry - xsh;
                    r_crz <= r_crz + ctab;
                end else begin
                    r_crx <= r_crx - ysh;
                    r_cry <= r_cry + xsh;
                    r_crz <= r_crz - ctab;
                end
            end
            ffc_pkg::S_CFIN_Y: r_yaw <= zang;
            ffc_pkg::S_CFIN_L: r_lat <= zang;
            ffc_pkg::S_MULL: begin
                r_linp <= $signed({1'b0, i_cfg.range_gain}) * err;
                r_dead <= aerr < ffc_pkg::DEADBAND;
            end
            ffc_pkg::S_MULA: r_angp <= $signed({1'b0, i_cfg.head_gain}) * asum;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_is_stop <= i_cmd.stop;
            if (i_cmd.stop) begin
                o_forward_distance <= '0;
                o_lateral_position <= '0;
                o_yaw_angle        <= '0;
                o_linear_speed     <= '0;
                o_angular_speed    <= '0;
            end else begin
                o_forward_distance <= rng;
                o_lateral_position <= r_lat_pos;
                o_yaw_angle        <= r_yaw;
                o_linear_speed     <= lin;
                o_angular_speed    <= ang;
            end
        end
    end

endmodule

/* src/fiducial_follow_controller_top.sv */
// top level: configuration registers, sequencer and datapath
// a found tag gives its word once the sequence from S_SQ to S_DONE is through and the output is free
// a missed frame that triggers a stop goes from idle straight to S_DONE and then to the output register
// one frame at a time: the input is not ready again until the word is loaded, held up by the serial
// square root, the two restoring dividers and the shared 16-step cordic
// reset (synchronous, active low) restores register defaults and clears the miss count
module fiducial_follow_controller_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_tag_found,
    input  logic [13:0]         i_corner0_x,
    input  logic [13:0]         i_corner0_y,
    input  logic [13:0]         i_corner1_x,
    input  logic [13:0]         i_corner1_y,
    input  logic [13:0]         i_corner2_x,
    input  logic [13:0]         i_corner2_y,
    input  logic [13:0]         i_centre_x,
    input  logic [13:0]         i_centre_y,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_forward_distance,
    output logic signed [15:0]  o_lateral_position,
    output logic signed [14:0]  o_yaw_angle,
    output logic signed [14:0]  o_linear_speed,
    output logic signed [15:0]  o_angular_speed,
    output logic                o_is_stop
);

    ffc_pkg::t_cfg    r_cfg;
    ffc_pkg::t_cmd    cmd;
    ffc_pkg::t_status status;
    logic             unused_y;

    assign unused_y = ^i_centre_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_len    <= ffc_pkg::RST_EDGE_LEN;
            r_cfg.focal_x     <= ffc_pkg::RST_FOCAL_X;
            r_cfg.principal_x <= ffc_pkg::RST_PRINCIPAL_X;
            r_cfg.range_set   <= ffc_pkg::RST_RANGE_SET;
            r_cfg.range_gain  <= ffc_pkg::RST_RANGE_GAIN;
            r_cfg.head_gain   <= ffc_pkg::RST_HEAD_GAIN;
            r_cfg.lin_limit   <= ffc_pkg::RST_LIN_LIMIT;
            r_cfg.rot_limit   <= ffc_pkg::RST_ROT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ffc_pkg::CFG_EDGE_LEN:    r_cfg.edge_len    <= i_cfg_data;
                ffc_pkg::CFG_FOCAL_X:     r_cfg.focal_x     <= i_cfg_data;
                ffc_pkg::CFG_PRINCIPAL_X: r_cfg.principal_x <= i_cfg_data[13:0];
                ffc_pkg::CFG_RANGE_SET:   r_cfg.range_set   <= i_cfg_data;
                ffc_pkg::CFG_RANGE_GAIN:  r_cfg.range_gain  <= i_cfg_data;
                ffc_pkg::CFG_HEAD_GAIN:   r_cfg.head_gain   <= i_cfg_data;
                ffc_pkg::CFG_LIN_LIMIT:   r_cfg.lin_limit   <= i_cfg_data[13:0];
                ffc_pkg::CFG_ROT_LIMIT:   r_cfg.rot_limit   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    ffc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_tag_found (i_tag_found & ~unused_y | i_tag_found),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready)
    );

    ffc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg              (r_cfg),
        .o_status           (status),
        .i_corner0_x        (i_corner0_x),
        .i_corner0_y        (i_corner0_y),
        .i_corner1_x        (i_corner1_x),
        .i_corner1_y        (i_corner1_y),
        .i_corner2_x        (i_corner2_x),
        .i_corner2_y        (i_corner2_y),
        .i_centre_x         (i_centre_x),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_forward_distance (o_forward_distance),
        .o_lateral_position (o_lateral_position),
        .o_yaw_angle        (o_yaw_angle),
        .o_linear_speed     (o_linear_speed),
        .o_angular_speed    (o_angular_speed),
        .o_is_stop          (o_is_stop)
    );

endmodule

/* src/ffc_checker.sv */
// port-level checks for the fiducial follow controller, bound to the top level
module ffc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                i_tag_found,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [15:0]         o_forward_distance,
    input  logic signed [15:0]  o_lateral_position,
    input  logic signed [14:0]  o_yaw_angle,
    input  logic signed [14:0]  o_linear_speed,
    input  logic signed [15:0]  o_angular_speed,
    input  logic                o_is_stop
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_stop |-> o_forward_distance == '0 &&
        o_lateral_position == '0 && o_yaw_angle == '0 &&
        o_linear_speed == '0 && o_angular_speed == '0)
        else $error("stop word carries nonzero fields");

    a_found_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_tag_found |=> !o_in_ready)
        else $error("ready while a found tag is in work");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_yaw_angle >= -15'sd12868 && o_yaw_angle <= 15'sd12868 &&
        o_linear_speed >= -15'sd8192 && o_linear_speed <= 15'sd8192 &&
        o_angular_speed >= -16'sd16384 && o_angular_speed <= 16'sd16384)
        else $error("output outside clamp range");

endmodule

bind fiducial_follow_controller_top ffc_checker u_ffc_checker (.*);

/* dv/tb_top.sv */
// testbench for the fiducial follow controller: directed table, corner settings, then random frames
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [15:0] rng;
        logic [15:0] lat;
        logic [14:0] yaw;
        logic [14:0] lin;
        logic [15:0] ang;
        logic        stop;
    } t_follow;

    typedef struct {
        logic        found;
        logic [13:0] c[8];
        logic        known;
        t_follow     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_tag_found = 1'b0;
    logic [13:0] i_corner0_x = '0, i_corner0_y = '0, i_corner1_x = '0, i_corner1_y = '0;
    logic [13:0] i_corner2_x = '0, i_corner2_y = '0, i_centre_x = '0, i_centre_y = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_forward_distance;
    logic signed [15:0] o_lateral_position;
    logic signed [14:0] o_yaw_angle;
    logic signed [14:0] o_linear_speed;
    logic signed [15:0] o_angular_speed;
    logic        o_is_stop;

    fiducial_follow_controller_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    longint  reg_val[8];
    int      miss_run;
    t_follow pending_cmds[$];
    int      fail_cnt = 0;
    int      send_idle = 0;
    int      recv_stall = 0;
    int      hold_off = 0;

    function automatic longint div_floor(longint a, int s);
        return a >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint heading_q12(longint y, longint x);
        longint z, t, xs, ys;
        longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 102944;
            end else begin
                t = x; x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += tab[i];
            end else begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        return clip((z + 8) >>> 4, -12868, 12868);
    endfunction

    function automatic longint isqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // returns 1 when the frame gives a command word
    function automatic bit predict_word(input t_row r, output t_follow o);
        longint v[8], dx, dy, l, d, x, xs, yaw, lat, err, lin, ang, lim, lt;
        for (int i = 0; i < 8; i++) v[i] = r.c[i];
        o = '{default: '0};
        if (!r.found) begin
            if (miss_run < 7) miss_run++;
            if (miss_run <= 3) return 0;
            o.stop = 1'b1;
            return 1;
        end
        miss_run = 0;
        dx = v[0] - v[2];
        dy = v[1] - v[3];
        l = isqrt((dx * dx + dy * dy) * 256);
        d = (l == 0) ? 65535 : clip((reg_val[0] * reg_val[1]) / l, 0, 65535);
        x = (reg_val[1] == 0) ? 0 : ((v[6] - reg_val[2]) * d) / reg_val[1];
        xs = clip(x, -32768, 32767);
        yaw = heading_q12(v[1] - v[5], v[0] - v[4]);
        lat = heading_q12(xs, d);
        err = d - reg_val[3];
        if ((err < 0 ? -err : err) * 10 < 4096) begin
            lin = 0;
        end else begin
            lim = reg_val[6] > 8192 ? 8192 : reg_val[6];
            lin = clip(div_floor(reg_val[4] * err, 12), -lim, lim);
        end
        lim = reg_val[7] > 16384 ? 16384 : reg_val[7];
        ang = clip(div_floor(reg_val[5] * (2 * lat + yaw), 13), -lim, lim);
        lt = clip(-x, -32768, 32767);
        o.rng = d[15:0];
        o.lat = lt[15:0];
        o.yaw = yaw[14:0];
        o.lin = lin[14:0];
        o.ang = ang[15:0];
        return 1;
    endfunction

    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < 8) begin
            case (idx)
                ffc_pkg::CFG_PRINCIPAL_X, ffc_pkg::CFG_LIN_LIMIT: reg_val[idx] = val[13:0];
                ffc_pkg::CFG_ROT_LIMIT:                           reg_val[idx] = val[14:0];
                default:                                          reg_val[idx] = val;
            endcase
        end
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic send_frame(t_row r);
        t_follow e;
        while (($urandom_range(99) < send_idle)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tag_found <= r.found;
        {i_corner0_x, i_corner0_y, i_corner1_x, i_corner1_y} <= {r.c[0], r.c[1], r.c[2], r.c[3]};
        {i_corner2_x, i_corner2_y, i_centre_x, i_centre_y} <= {r.c[4], r.c[5], r.c[6], r.c[7]};
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_word(r, e)) begin
            if (r.known) e = r.res;
            pending_cmds.push_back(e);
        end
    endtask

    function automatic t_row rand_frame();
        t_row r;
        int cx, cy, s;
        r.known = 0;
        r.res = '{default: '0};
        r.found = ($urandom_range(9) != 0);
        if ($urandom_range(4) == 0) begin
            for (int i = 0; i < 8; i++) r.c[i] = 14'($urandom);
        end else begin
            cx = $urandom_range(15000, 1000);
            cy = $urandom_range(15000, 1000);
            s = $urandom_range(900, 8);
            r.c[0] = 14'(cx - s); r.c[1] = 14'(cy - s + int'($urandom_range(16)));
            r.c[2] = 14'(cx + s); r.c[3] = 14'(cy - s);
            r.c[4] = 14'(cx + s + int'($urandom_range(16))); r.c[5] = 14'(cy + s);
            r.c[6] = 14'(cx + int'($urandom_range(8)) - 4); r.c[7] = 14'(cy);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_follow e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("word with nothing expected");
                fail_cnt++;
            end else begin
                e = pending_cmds.pop_front();
                if (o_forward_distance !== e.rng) begin
                    $error("forward_distance exp %0d got %0d", e.rng, o_forward_distance);
                    fail_cnt++;
                end
                if (o_lateral_position !== e.lat) begin
                    $error("lateral_position exp %0h got %0h", e.lat, o_lateral_position);
                    fail_cnt++;
                end
                if (o_yaw_angle !== e.yaw) begin
                    $error("yaw_angle exp %0h got %0h", e.yaw, o_yaw_angle);
                    fail_cnt++;
                end
                if (o_linear_speed !== e.lin) begin
                    $error("linear_speed exp %0h got %0h", e.lin, o_linear_speed);
                    fail_cnt++;
                end
                if (o_angular_speed !== e.ang) begin
                    $error("angular_speed exp %0h got %0h", e.ang, o_angular_speed);
                    fail_cnt++;
                end
                if (o_is_stop !== e.stop) begin
                    $error("is_stop exp %0b got %0b", e.stop, o_is_stop);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_row dir_rows[$];
        t_row r;
        int   idle_tab[4] = '{0, 53, 0, 26};
        int   stall_tab[4] = '{0, 0, 53, 26};
        reg_val = '{3277, 4944, 5120, 2458, 3277, 8192, 1229, 4096};
        miss_run = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: misses into stop, degenerate and extreme frames
        r.known = 0;
        r.res = '{default: '0};
        r.found = 0;
        r.c = '{default: '0};
        for (int i = 0; i < 6; i++) dir_rows.push_back(r);
        r.found = 1; r.known = 1;
        r.c = '{0, 0, 0, 0, 0, 0, 5120, 0};
        r.res = '{16'hFFFF, 16'd0, 15'd0, 15'd1229, 16'd0, 1'b0};
        dir_rows.push_back(r);
        r.known = 0;
        r.c = '{16383, 16383, 0, 0, 0, 0, 16383, 16383};
        dir_rows.push_back(r);
        r.c = '{0, 0, 16383, 16383, 16383, 16383, 0, 0};
        dir_rows.push_back(r);
        r.c = '{100, 200, 900, 200, 900, 1000, 16383, 5};
        dir_rows.push_back(r);
        r.c = '{5000, 5000, 5160, 5000, 4000, 4000, 0, 9};
        dir_rows.push_back(r);
        r.c = '{5000, 5000, 5001, 5000, 5000, 6000, 5120, 0};
        dir_rows.push_back(r);
        r.found = 0;
        for (int i = 0; i < 9; i++) dir_rows.push_back(r);
        foreach (dir_rows[i]) send_frame(dir_rows[i]);
        drain();

        // corner settings: zero focal, bad index and an extreme centre x
        write_reg(ffc_pkg::CFG_FOCAL_X, 16'd0);
        write_reg(4'd9, 16'hFFFF);
        r = '{found: 1, c: '{100, 100, 300, 100, 300, 300, 0, 0}, known: 0,
              res: '{default: '0}};
        send_frame(r);
        r.c[6] = 16383;
        send_frame(r);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle = idle_tab[ph % 4];
            recv_stall = stall_tab[ph % 4];
            case (ph)
                0: begin
                    write_reg(ffc_pkg::CFG_EDGE_LEN, 16'd1);
                    write_reg(ffc_pkg::CFG_FOCAL_X, 16'd16);
                    write_reg(ffc_pkg::CFG_PRINCIPAL_X, 16'd0);
                    write_reg(ffc_pkg::CFG_RANGE_SET, 16'd0);
                    write_reg(ffc_pkg::CFG_RANGE_GAIN, 16'd0);
                    write_reg(ffc_pkg::CFG_HEAD_GAIN, 16'd0);
                    write_reg(ffc_pkg::CFG_LIN_LIMIT, 16'd0);
                    write_reg(ffc_pkg::CFG_ROT_LIMIT, 16'd0);
                end
                1: begin
                    write_reg(ffc_pkg::CFG_EDGE_LEN, 16'hFFFF);
                    write_reg(ffc_pkg::CFG_FOCAL_X, 16'hFFFF);
                    write_reg(ffc_pkg::CFG_PRINCIPAL_X, 16'h3FFF);
                    write_reg(ffc_pkg::CFG_RANGE_SET, 16'hFFFF);
                    write_reg(ffc_pkg::CFG_RANGE_GAIN, 16'hFFFF);
                    write_reg(ffc_pkg::CFG_HEAD_GAIN, 16'hFFFF);
                    write_reg(ffc_pkg::CFG_LIN_LIMIT, 16'hFFFF);
                    write_reg(ffc_pkg::CFG_ROT_LIMIT, 16'hFFFF);
                end
                2: begin
                    write_reg(ffc_pkg::CFG_EDGE_LEN, 16'd3277);
                    write_reg(ffc_pkg::CFG_FOCAL_X, 16'd4944);
                    write_reg(ffc_pkg::CFG_PRINCIPAL_X, 16'd5120);
                    write_reg(ffc_pkg::CFG_RANGE_SET, 16'd2458);
                    write_reg(ffc_pkg::CFG_RANGE_GAIN, 16'd3277);
                    write_reg(ffc_pkg::CFG_HEAD_GAIN, 16'd8192);
                    write_reg(ffc_pkg::CFG_LIN_LIMIT, 16'd8192);
                    write_reg(ffc_pkg::CFG_ROT_LIMIT, 16'd16384);
                end
                default: begin
                    for (int k = 0; k < 8; k++) write_reg(k[3:0], 16'($urandom));
                    if (reg_val[1] < 16) write_reg(ffc_pkg::CFG_FOCAL_X, 16'd16);
                end
            endcase
            if (ph == 4) hold_off = 3000;
            for (int n = 0; n < 125; n++) send_frame(rand_frame());
            drain();
        end

        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* sim.f */
src/ffc_pkg.sv
src/ffc_ctrl.sv
src/ffc_dp.sv
src/fiducial_follow_controller_top.sv
src/ffc_checker.sv
dv/tb_top.sv
